// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the keyed table.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every sampled edge
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ktpl_pkg.sv -----
// Types and constants for the keyed table with parent links.
// No dependencies; imported by keyed_table_with_parent_links_core.
package ktpl_pkg;

   localparam int KEY_W          = 32;
   localparam int INFO_W         = 16;
   localparam int OP_W           = 2;
   localparam int STATUS_W       = 3;
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int MATCH_W        = $clog2(MAX_RESULTS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT     = 2'd0,
      OP_FIND_KEY   = 2'd1,
      OP_FIND_RANGE = 2'd2,
      OP_DELETE     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_DUP       = 3'd1,
      STATUS_NO_PARENT = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NOT_FOUND = 3'd4,
      STATUS_IS_PARENT = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      FINISH,
      COMPACT
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  parent;
      logic [INFO_W-1:0] info;
   } entry_type;

   typedef struct packed {
      status_type status;
      logic       hit;
      entry_type  ent;
      logic       last;
   } rsp_type;

endpackage

// ----- src/keyed_table_with_parent_links_core.sv -----
// Keyed table with parent links: top level, table memory and request sequencer.
// Depends on ktpl_pkg and assert_macros.svh.
//
// A packed table of up to TABLE_DEPTH entries (key, parent key, info handle) kept in one
// synchronous memory with one read and one write port. One request is handled at a time:
// every request scans the stored entries one per cycle through the memory read port, but a
// find stalls while a match waits on a held result register. A successful delete then compacts
// the table, shifting every later entry down one slot at one entry per cycle. Finds emit
// matches in table order, last-flagged, capped at MAX_RESULTS; a find without matches gives
// one not-found result. The result register decouples the two channels, so a new request
// is taken while a result waits.
`include "assert_macros.svh"

module keyed_table_with_parent_links_core #(
   parameter int TABLE_DEPTH = ktpl_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ktpl_pkg::OP_W-1:0]     req_operation,
   input  logic [ktpl_pkg::KEY_W-1:0]    req_entry_key,
   input  logic [ktpl_pkg::KEY_W-1:0]    req_parent_key,
   input  logic [ktpl_pkg::INFO_W-1:0]   req_info_handle,
   input  logic [ktpl_pkg::KEY_W-1:0]    req_range_low,
   input  logic [ktpl_pkg::KEY_W-1:0]    req_range_high,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ktpl_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_hit,
   output logic [ktpl_pkg::KEY_W-1:0]    rsp_found_key,
   output logic [ktpl_pkg::KEY_W-1:0]    rsp_found_parent,
   output logic [ktpl_pkg::INFO_W-1:0]   rsp_found_info,
   output logic                          rsp_last
);
   import ktpl_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [MATCH_W-1:0] MAX_C = MATCH_W'(MAX_RESULTS);

   // Table memory
   entry_type mem [TABLE_DEPTH];
   entry_type mem_q;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   // Control state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [MATCH_W-1:0] nmatch_ff, nmatch_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Request and scan payload
   op_type             op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   par_ff, par_in;
   logic [INFO_W-1:0]  info_ff, info_in;
   logic [KEY_W-1:0]   lo_ff, lo_in;
   logic [KEY_W-1:0]   hi_ff, hi_in;
   logic               dup_ff, dup_in;
   logic               parfound_ff, parfound_in;
   logic               isparent_ff, isparent_in;
   logic [IW-1:0]      pos_ff, pos_in;
   entry_type          pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               load_out;

   // Scan helpers
   logic       out_free;
   logic       is_find;
   logic       key_hit;
   logic       in_range;
   logic       match;
   logic       stall;
   logic       can_issue;
   logic       scan_done;
   logic       compact_done;
   status_type final_status;

   // Memory: one write port, one registered read port. Compaction reads slot j while
   // writing slot j-2, and insert writes only at the end, so accesses never collide.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_find   = (op_ff == OP_FIND_KEY) || (op_ff == OP_FIND_RANGE);
   assign key_hit   = (mem_q.key == key_ff);
   assign in_range  = (mem_q.parent >= lo_ff) && (mem_q.parent <= hi_ff);
   assign match     = (state_ff == SCAN) && rd_valid_ff && is_find && (nmatch_ff != MAX_C) &&
                      ((op_ff == OP_FIND_KEY) ? key_hit : in_range);
   assign stall     = match && pend_valid_ff && !out_free;
   assign can_issue = (issue_ff < count_ff) && (!is_find || (nmatch_ff != MAX_C));
   assign scan_done = (state_ff == SCAN) && !stall && !can_issue;
   assign compact_done = (state_ff == COMPACT) && (issue_ff == count_ff) && !rd_valid_ff;

   // Decide the single result of insert, delete and the closing result of a find
   always_comb begin
      final_status = STATUS_OK;
      unique case (op_ff)
         OP_INSERT: begin
            if ((key_ff == '0) || dup_ff) final_status = STATUS_DUP;
            else if ((par_ff != '0) && !parfound_ff) final_status = STATUS_NO_PARENT;
            else if (count_ff >= DEPTH_C) final_status = STATUS_FULL;
            else final_status = STATUS_OK;
         end
         OP_DELETE: begin
            if (key_ff == '0) final_status = STATUS_DUP;
            else if (isparent_ff) final_status = STATUS_IS_PARENT;
            else if (!dup_ff) final_status = STATUS_NOT_FOUND;
            else final_status = STATUS_OK;
         end
         OP_FIND_KEY, OP_FIND_RANGE: begin
            final_status = pend_valid_ff ? STATUS_OK : STATUS_NOT_FOUND;
         end
         default: final_status = STATUS_OK;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) state_in = SCAN;
         end
         SCAN: begin
            if (scan_done) state_in = FINISH;
         end
         FINISH: begin
            if (out_free) begin
               if ((op_ff == OP_DELETE) && (final_status == STATUS_OK)) state_in = COMPACT;
               else state_in = IDLE;
            end
         end
         COMPACT: begin
            if (compact_done) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_valid_in   = rd_valid_ff;
      rd_idx_in     = rd_idx_ff;
      pend_valid_in = pend_valid_ff;
      nmatch_in     = nmatch_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      par_in        = par_ff;
      info_in       = info_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      dup_in        = dup_ff;
      parfound_in   = parfound_ff;
      isparent_in   = isparent_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      load_out      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[IW-1:0];
      wr_data       = '{key: key_ff, parent: par_ff, info: info_ff};
      req_ready     = 1'b0;
      unique case (state_ff)
         IDLE: begin
            // Latch the request and clear scan flags
            req_ready = 1'b1;
            if (req_valid) begin
               op_in         = op_type'(req_operation);
               key_in        = req_entry_key;
               par_in        = req_parent_key;
               info_in       = req_info_handle;
               lo_in         = req_range_low;
               hi_in         = req_range_high;
               issue_in      = '0;
               rd_valid_in   = 1'b0;
               dup_in        = 1'b0;
               parfound_in   = 1'b0;
               isparent_in   = 1'b0;
               pend_valid_in = 1'b0;
               nmatch_in     = '0;
            end
         end
         SCAN: begin
            if (!stall) begin
               // Advance the read pointer
               rd_valid_in = can_issue;
               if (can_issue) begin
                  rd_en     = 1'b1;
                  rd_idx_in = issue_ff[IW-1:0];
                  issue_in  = issue_ff + 1'b1;
               end
               // Evaluate the entry that came back from memory
               if (rd_valid_ff) begin
                  if (key_hit) begin
                     dup_in = 1'b1;
                     pos_in = rd_idx_ff;
                  end
                  if (mem_q.key == par_ff) parfound_in = 1'b1;
                  if (mem_q.parent == key_ff) isparent_in = 1'b1;
               end
               // Hold one match back so the final one can carry last
               if (match) begin
                  if (pend_valid_ff) begin
                     load_out = 1'b1;
                     rsp_in   = '{status: STATUS_OK, hit: 1'b1, ent: pend_ff, last: 1'b0};
                  end
                  pend_in       = mem_q;
                  pend_valid_in = 1'b1;
                  nmatch_in     = nmatch_ff + 1'b1;
               end
            end
         end
         FINISH: begin
            if (out_free) begin
               load_out = 1'b1;
               if (is_find && pend_valid_ff) begin
                  rsp_in = '{status: STATUS_OK, hit: 1'b1, ent: pend_ff, last: 1'b1};
               end else begin
                  rsp_in = '{status: final_status, hit: 1'b0, ent: '0, last: 1'b1};
               end
               // Append on a good insert
               if ((op_ff == OP_INSERT) && (final_status == STATUS_OK)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               // Start compaction just past the removed slot
               if ((op_ff == OP_DELETE) && (final_status == STATUS_OK)) begin
                  issue_in    = CW'(pos_ff) + 1'b1;
                  rd_valid_in = 1'b0;
               end
            end
         end
         COMPACT: begin
            // Read slot j, write it to slot j-1 in the next cycle
            rd_valid_in = (issue_ff < count_ff);
            if (issue_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_idx_in = issue_ff[IW-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - 1'b1;
               wr_data = mem_q;
            end
            if (compact_done) count_in = count_ff - 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Result register: load a new transfer, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         nmatch_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         nmatch_ff     <= nmatch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      par_ff      <= par_in;
      info_ff     <= info_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      dup_ff      <= dup_in;
      parfound_ff <= parfound_in;
      isparent_ff <= isparent_in;
      pos_ff      <= pos_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_found_key    = rsp_ff.ent.key;
   assign rsp_found_parent = rsp_ff.ent.parent;
   assign rsp_found_info   = rsp_ff.ent.info;
   assign rsp_last         = rsp_ff.last;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= DEPTH_C, "entry count exceeds table depth")
   `ASSERT_IMPL(a_no_overwrite, load_out, out_free, "result register overwritten while held")
   `ASSERT_IMPL(a_append_room, wr_en && (state_ff == FINISH), count_ff < DEPTH_C,
      "insert into a full table")
   `ASSERT_NEXT(a_delete_shrinks, compact_done, count_ff == CW'($past(count_ff) - 1'b1),
      "delete did not shrink the table by one")

endmodule
